>>> rtl/core/oic_pkg.sv
// Package for the online interval colouring unit: sizes, outcome codes and
// sequencer states. No dependencies.
package oic_pkg;
	localparam int MaxIntervals = 256;
	localparam int IdxBits = 8;
	localparam int CntBits = 9;
	localparam int MaxLevels = 16;
	localparam int LvlBits = 4;
	localparam int CoordBits = 16;
	localparam int ColorsPerLevel = 3;

	typedef logic [2:0] outcome_t;
	localparam outcome_t OutOk = 3'd0;
	localparam outcome_t OutNoLevel = 3'd1;
	localparam outcome_t OutBad = 3'd2;
	localparam outcome_t OutFull = 3'd3;
	localparam outcome_t OutNoColor = 3'd4;

	localparam logic [1:0] NoColor = 2'd3;

	typedef enum logic [2:0] {
		StIdle,
		StSearch,
		StOuter,
		StInner,
		StJudge,
		StColor,
		StStore,
		StDone
	} state_t;
endpackage

>>> rtl/core/online_interval_coloring_unit.sv
// Top level of the online interval colouring unit.
// A rejected interval goes from the search state straight to the result. Otherwise the result
// follows a binary search over up to ceil(log2(levels+1)) steps, each an overlap walk with
// one read per cycle, then the colour walk and the store.
// One item at a time: a new transfer is taken in the cycle after the result leaves.
// Reset clears the entry count and sets num_levels to 4; entries need no clear.
module online_interval_coloring_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] interval_start,
	input  logic [15:0] interval_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  assigned_level,
	output logic [5:0]  assigned_color,
	output logic [2:0]  outcome
);
	logic [15:0] mem_s [oic_pkg::MaxIntervals];
	logic [15:0] mem_e [oic_pkg::MaxIntervals];
	logic [3:0]  mem_l [oic_pkg::MaxIntervals];
	logic [1:0]  mem_c [oic_pkg::MaxIntervals];

	oic_pkg::state_t state_q, state_d;
	logic [4:0]  nl_q;
	logic [8:0]  count_q;
	logic [15:0] s_q, e_q, p_q;
	logic [4:0]  lo_q, hi_q, nle_q;
	logic [3:0]  mid_q;
	logic [8:0]  j_q, k_q;
	logic [8:0]  cnt_q, best_q;
	logic [2:0]  used_q;
	logic        rd_ok_q;
	logic [15:0] rs_q, re_q;
	logic [3:0]  rl_q;
	logic [1:0]  rc_q;
	logic [7:0]  raddr;
	logic [4:0]  lvl_q;
	logic [5:0]  col_q;
	logic [2:0]  out_q;
	logic [1:0]  ci;
	logic        hit, eligible;

	// One memory read per cycle: address from whichever walk is running.
	always_comb begin
		raddr = (state_q == oic_pkg::StInner) ? k_q[7:0] : j_q[7:0];
	end

	always_ff @(posedge clk) begin
		rs_q <= mem_s[raddr];
		re_q <= mem_e[raddr];
		rl_q <= mem_l[raddr];
		rc_q <= mem_c[raddr];
		if (state_q == oic_pkg::StStore) begin
			mem_s[count_q[7:0]] <= s_q;
			mem_e[count_q[7:0]] <= e_q;
			mem_l[count_q[7:0]] <= lvl_q[3:0];
			mem_c[count_q[7:0]] <= ci;
		end
	end

	assign hit = (re_q > s_q) && (rs_q < e_q);
	assign eligible = hit && ({1'b0, rl_q} <= {1'b0, mid_q});

	always_comb begin
		if (!used_q[0]) ci = 2'd0;
		else if (!used_q[1]) ci = 2'd1;
		else if (!used_q[2]) ci = 2'd2;
		else ci = oic_pkg::NoColor;
	end

	always_comb begin
		state_d = state_q;
		in_ready = (state_q == oic_pkg::StIdle);
		out_valid = (state_q == oic_pkg::StDone);
		unique case (state_q)
			oic_pkg::StIdle: if (in_valid) state_d = oic_pkg::StSearch;
			oic_pkg::StSearch: begin
				if (out_q != oic_pkg::OutOk) state_d = oic_pkg::StDone;
				else if (lo_q > hi_q) begin
					if (lo_q >= nle_q) state_d = oic_pkg::StDone;
					else state_d = oic_pkg::StColor;
				end else state_d = oic_pkg::StOuter;
			end
			oic_pkg::StOuter: begin
				if (!rd_ok_q) begin
					if (j_q >= count_q) state_d = oic_pkg::StJudge;
				end else if (eligible) state_d = oic_pkg::StInner;
			end
			oic_pkg::StInner: if (!rd_ok_q && k_q >= count_q) state_d = oic_pkg::StOuter;
			oic_pkg::StJudge: begin
				if (best_q <= {5'd0, mid_q} && mid_q == 4'd0) state_d = oic_pkg::StColor;
				else state_d = oic_pkg::StSearch;
			end
			oic_pkg::StColor: if (!rd_ok_q && j_q >= count_q) state_d = oic_pkg::StStore;
			oic_pkg::StStore: state_d = oic_pkg::StDone;
			oic_pkg::StDone: if (out_ready) state_d = oic_pkg::StIdle;
			default: state_d = oic_pkg::StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oic_pkg::StIdle;
			nl_q <= 5'd4;
			count_q <= '0;
		end else begin
			if (cfg_we) nl_q <= cfg_wdata;
			state_q <= state_d;
			unique case (state_q)
				oic_pkg::StIdle: if (in_valid) begin
					s_q <= interval_start;
					e_q <= interval_end;
					lo_q <= '0;
					if (nl_q == 5'd0) begin
						nle_q <= 5'd1;
						hi_q <= 5'd0;
					end else if (nl_q > 5'(oic_pkg::MaxLevels)) begin
						nle_q <= 5'(oic_pkg::MaxLevels);
						hi_q <= 5'(oic_pkg::MaxLevels - 1);
					end else begin
						nle_q <= nl_q;
						hi_q <= nl_q - 5'd1;
					end
					lvl_q <= '0;
					col_q <= '0;
					if (interval_start >= interval_end) out_q <= oic_pkg::OutBad;
					else if (count_q == 9'(oic_pkg::MaxIntervals)) out_q <= oic_pkg::OutFull;
					else out_q <= oic_pkg::OutOk;
				end
				oic_pkg::StSearch: begin
					j_q <= '0;
					best_q <= '0;
					rd_ok_q <= 1'b0;
					used_q <= '0;
					if (out_q == oic_pkg::OutOk && lo_q > hi_q) begin
						if (lo_q >= nle_q) begin
							out_q <= oic_pkg::OutNoLevel;
							lvl_q <= nle_q;
						end else begin
							lvl_q <= lo_q;
							mid_q <= lo_q[3:0];
						end
					end else mid_q <= 4'((lo_q + hi_q) >> 1);
				end
				oic_pkg::StOuter: begin
					// Fetch entry j; its data is valid in the next cycle.
					if (!rd_ok_q) begin
						if (j_q < count_q) rd_ok_q <= 1'b1;
					end else begin
						rd_ok_q <= 1'b0;
						if (eligible) begin
							p_q <= rs_q;
							k_q <= '0;
							cnt_q <= '0;
						end else j_q <= j_q + 9'd1;
					end
				end
				oic_pkg::StInner: begin
					if (!rd_ok_q) begin
						if (k_q >= count_q) begin
							if (cnt_q > best_q) best_q <= cnt_q;
							j_q <= j_q + 9'd1;
						end else rd_ok_q <= 1'b1;
					end else begin
						rd_ok_q <= 1'b0;
						if (eligible && rs_q <= p_q && p_q < re_q) cnt_q <= cnt_q + 9'd1;
						k_q <= k_q + 9'd1;
					end
				end
				oic_pkg::StJudge: begin
					// A fit at level zero ends the search there and starts the colour walk.
					if (best_q <= {5'd0, mid_q}) begin
						if (mid_q == 4'd0) begin
							lvl_q <= '0;
							j_q <= '0;
						end else hi_q <= {1'b0, mid_q} - 5'd1;
					end else lo_q <= {1'b0, mid_q} + 5'd1;
				end
				oic_pkg::StColor: begin
					if (!rd_ok_q) begin
						if (j_q < count_q) rd_ok_q <= 1'b1;
					end else begin
						rd_ok_q <= 1'b0;
						if (hit && rl_q == mid_q && rc_q != oic_pkg::NoColor)
							used_q[rc_q] <= 1'b1;
						j_q <= j_q + 9'd1;
					end
				end
				oic_pkg::StStore: begin
					count_q <= count_q + 9'd1;
					if (ci == oic_pkg::NoColor) out_q <= oic_pkg::OutNoColor;
					else col_q <= 6'(lvl_q * 3) + {4'd0, ci} + 6'd1;
				end
				oic_pkg::StDone: ;
				default: ;
			endcase
		end
	end

	assign assigned_level = lvl_q;
	assign assigned_color = col_q;
	assign outcome = out_q;
endmodule
